>>> hw/rtl/npts_pkg.sv
package npts_pkg;

	localparam int COORD_W    = 24;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int DOT_W      = 2 * DIFF_W + 2;
	localparam int DIG_W      = 13;
	localparam int NDIG       = 4;
	localparam int PROD_W     = 2 * DOT_W;
	localparam int V_W        = PROD_W + 4;
	localparam int DIV_W      = V_W + 2;
	localparam int WFRAC      = 24;
	localparam int SQ_W       = 50;
	localparam int DIST_W     = 25;
	localparam int FACE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_FACES  = 65536;
	localparam int FACE_LIMIT = (MAX_FACES - 1 > 65535) ? 65535 : MAX_FACES - 1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		coord_t            px;
		coord_t            py;
		coord_t            pz;
		logic [SQ_W-1:0]   sq;
		logic              last;
	} cand_t;

	typedef enum logic [1:0] {
		CFG_QUERY_X,
		CFG_QUERY_Y,
		CFG_QUERY_Z
	} cfg_reg_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_DIFF,
		F_DOT,
		F_WMUL,
		F_VSUM,
		F_CLASS,
		F_DIV,
		F_BLEND,
		F_SQ,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		R_A,
		R_B,
		R_C,
		R_AB,
		R_AC,
		R_BC,
		R_FACE
	} region_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SQRT,
		B_OUT
	} back_state_t;

endpackage

>>> hw/rtl/nearest_point_on_triangle_set_unit.sv
// Channel   Signals                                   Direction  Moves
// in        in_valid / in_ready, vert_*, last_tri..  to block   one triangle item
// out       out_valid / out_ready, nearest_*, ...     from block one result item
// cfg       cfg_valid / cfg_ready, cfg_index, cfg_data to block one query register
//
// In the front sequencer a vertex result skips the division and the blend, an
// edge result takes one division and the face interior two; the 25x25 dot
// multiplier, the 52x13 digit multiplier and the one-bit-a-cycle divider
// do the arithmetic. The last item of a search runs a square root in the
// back end before its result shows. Reset clears the query to the origin
// and the running best to infinity. A two-item queue between the front
// and the back lets the front finish the next triangle while a result waits.
module nearest_point_on_triangle_set_unit import npts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  coord_t                vert_a_x,
	input  coord_t                vert_a_y,
	input  coord_t                vert_a_z,
	input  coord_t                vert_b_x,
	input  coord_t                vert_b_y,
	input  coord_t                vert_b_z,
	input  coord_t                vert_c_x,
	input  coord_t                vert_c_y,
	input  coord_t                vert_c_z,
	input  logic                  last_triangle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output coord_t                nearest_x,
	output coord_t                nearest_y,
	output coord_t                nearest_z,
	output logic [SQ_W-1:0]       squared_distance,
	output logic [DIST_W-1:0]     distance,
	output logic [FACE_W-1:0]     face_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  coord_t                cfg_data
);

	vec_t  query_q;
	vec_t  vert_a, vert_b, vert_c;
	cand_t fq_data, qb_data;
	logic  fq_valid, fq_ready, qb_valid, qb_ready;

	// Writes are always taken; an index past the query registers is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_QUERY_X: query_q.x <= cfg_data;
				CFG_QUERY_Y: query_q.y <= cfg_data;
				CFG_QUERY_Z: query_q.z <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign vert_a = '{x: vert_a_x, y: vert_a_y, z: vert_a_z};
	assign vert_b = '{x: vert_b_x, y: vert_b_y, z: vert_b_z};
	assign vert_c = '{x: vert_c_x, y: vert_c_y, z: vert_c_z};

	// Front: classify the region and produce the candidate point and distance.
	npts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vert_a     (vert_a),
		.vert_b     (vert_b),
		.vert_c     (vert_c),
		.last_in    (last_triangle),
		.query      (query_q),
		.cand_valid (fq_valid),
		.cand_ready (fq_ready),
		.cand       (fq_data)
	);

	// Hold up to two candidates so each side stalls on its own.
	npts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	// Back: keep the running minimum, and on the last item take the root.
	npts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (qb_valid),
		.cand_ready (qb_ready),
		.cand       (qb_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (nearest_x),
		.out_y      (nearest_y),
		.out_z      (nearest_z),
		.out_sq     (squared_distance),
		.out_dist   (distance),
		.out_face   (face_index)
	);

endmodule

>>> hw/rtl/npts_front.sv
module npts_front import npts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  vec_t  vert_a,
	input  vec_t  vert_b,
	input  vec_t  vert_c,
	input  logic  last_in,
	input  vec_t  query,
	output logic  cand_valid,
	input  logic  cand_ready,
	output cand_t cand
);

	front_state_t state_q, state_d;

	coord_t a_q [3];
	coord_t b_q [3];
	coord_t c_q [3];
	coord_t p   [3];
	coord_t q_q [3];
	logic   last_q;

	logic signed [DIFF_W-1:0] ab_q [3];
	logic signed [DIFF_W-1:0] ac_q [3];
	logic signed [DIFF_W-1:0] bc_q [3];
	logic signed [DIFF_W-1:0] ap_q [3];
	logic signed [DIFF_W-1:0] bp_q [3];
	logic signed [DIFF_W-1:0] cp_q [3];

	logic signed [DOT_W-1:0]  dot_q [6];
	logic signed [DOT_W-1:0]  acc_q;
	logic [1:0]               comp_q;
	logic [2:0]               dot_idx_q;

	logic signed [PROD_W-1:0] prod_q [6];
	logic [PROD_W-1:0]        wacc_q;
	logic [2:0]               widx_q;
	logic [1:0]               wdig_q;

	logic signed [V_W-1:0]    va_q, vb_q, vc_q;
	region_t                  region_q, region_c;

	logic signed [DIV_W-1:0]  num_q, den_q, num_c, den_c;
	logic [DIV_W-1:0]         rem_q;
	logic [WFRAC-1:0]         quo_q;
	logic [4:0]               dstep_q;
	logic                     div_sel_q;
	logic [WFRAC:0]           w1_q, w2_q;

	logic [1:0]               coord_q;
	logic                     term_q;
	logic signed [50:0]       bacc_q;
	logic [SQ_W-1:0]          sq_q;

	// dot products
	logic signed [DIFF_W-1:0]   du, dv;
	logic signed [2*DIFF_W-1:0] dprod;
	logic signed [DOT_W-1:0]    dprod_x, dsum;

	always_comb begin
		p[0] = query.x;
		p[1] = query.y;
		p[2] = query.z;
	end

	assign du = dot_idx_q[0] ? ac_q[comp_q] : ab_q[comp_q];
	always_comb begin
		case (dot_idx_q[2:1])
			2'd0:    dv = ap_q[comp_q];
			2'd1:    dv = bp_q[comp_q];
			default: dv = cp_q[comp_q];
		endcase
	end
	assign dprod   = du * dv;
	assign dprod_x = DOT_W'(dprod);
	assign dsum    = ((comp_q == 2'd0) ? '0 : acc_q) + dprod_x;

	// wide products, one 13-bit digit of the multiplier a cycle
	logic signed [DOT_W-1:0]  wx, wy;
	logic [DOT_W-1:0]         mx, my;
	logic [DIG_W-1:0]         dig;
	logic [DOT_W+DIG_W-1:0]   wpp;
	logic [PROD_W-1:0]        wsum;
	logic signed [PROD_W-1:0] wprod;

	always_comb begin
		case (widx_q)
			3'd0:    begin wx = dot_q[0]; wy = dot_q[3]; end
			3'd1:    begin wx = dot_q[2]; wy = dot_q[1]; end
			3'd2:    begin wx = dot_q[4]; wy = dot_q[1]; end
			3'd3:    begin wx = dot_q[0]; wy = dot_q[5]; end
			3'd4:    begin wx = dot_q[2]; wy = dot_q[5]; end
			default: begin wx = dot_q[4]; wy = dot_q[3]; end
		endcase
	end
	assign mx = wx[DOT_W-1] ? DOT_W'(-wx) : DOT_W'(wx);
	assign my = wy[DOT_W-1] ? DOT_W'(-wy) : DOT_W'(wy);
	always_comb begin
		case (wdig_q)
			2'd0:    dig = my[4*DIG_W-1:3*DIG_W];
			2'd1:    dig = my[3*DIG_W-1:2*DIG_W];
			2'd2:    dig = my[2*DIG_W-1:DIG_W];
			default: dig = my[DIG_W-1:0];
		endcase
	end
	assign wpp   = mx * dig;
	assign wsum  = ((wdig_q == 2'd0) ? '0 : (wacc_q << DIG_W)) + PROD_W'(wpp);
	assign wprod = (wx[DOT_W-1] ^ wy[DOT_W-1]) ? -$signed(wsum) : $signed(wsum);

	// region tests
	logic signed [DOT_W-1:0] d1, d2, d3, d4, d5, d6;
	logic signed [DOT_W:0]   e13, e26, e43, e56;
	logic signed [DOT_W+1:0] ebc;
	logic signed [V_W-1:0]   vsum, p0x, p1x, p2x, p3x, p4x, p5x;

	assign d1 = dot_q[0];
	assign d2 = dot_q[1];
	assign d3 = dot_q[2];
	assign d4 = dot_q[3];
	assign d5 = dot_q[4];
	assign d6 = dot_q[5];
	assign e13 = (DOT_W+1)'(d1) - (DOT_W+1)'(d3);
	assign e26 = (DOT_W+1)'(d2) - (DOT_W+1)'(d6);
	assign e43 = (DOT_W+1)'(d4) - (DOT_W+1)'(d3);
	assign e56 = (DOT_W+1)'(d5) - (DOT_W+1)'(d6);
	assign ebc = (DOT_W+2)'(e43) + (DOT_W+2)'(e56);
	assign vsum = va_q + vb_q + vc_q;
	assign p0x = V_W'(prod_q[0]);
	assign p1x = V_W'(prod_q[1]);
	assign p2x = V_W'(prod_q[2]);
	assign p3x = V_W'(prod_q[3]);
	assign p4x = V_W'(prod_q[4]);
	assign p5x = V_W'(prod_q[5]);

	always_comb begin
		if (d1 <= 0 && d2 <= 0)                        region_c = R_A;
		else if (d3 >= 0 && d4 <= d3)                  region_c = R_B;
		else if (vc_q <= 0 && d1 >= 0 && d3 <= 0)      region_c = R_AB;
		else if (d6 >= 0 && d5 <= d6)                  region_c = R_C;
		else if (vb_q <= 0 && d2 >= 0 && d6 <= 0)      region_c = R_AC;
		else if (va_q <= 0 && e43 >= 0 && e56 >= 0)    region_c = R_BC;
		else                                           region_c = R_FACE;
	end

	always_comb begin
		case (region_c)
			R_AB:    begin num_c = DIV_W'(d1);   den_c = DIV_W'(e13);  end
			R_AC:    begin num_c = DIV_W'(d2);   den_c = DIV_W'(e26);  end
			R_BC:    begin num_c = DIV_W'(e43);  den_c = DIV_W'(ebc);  end
			default: begin num_c = DIV_W'(vb_q); den_c = DIV_W'(vsum); end
		endcase
	end

	logic                 is_vertex;
	assign is_vertex = (region_c == R_A) || (region_c == R_B) || (region_c == R_C);

	// restoring division, one quotient bit a cycle
	logic                 div_zero, div_one, div_fin, rge;
	logic [DIV_W-1:0]     rsh, den_u;
	logic [WFRAC-1:0]     qnext;
	logic [WFRAC:0]       fin_w;
	logic signed [DIV_W-1:0] vc_x;

	assign div_zero = (den_q <= 0) || (num_q <= 0);
	assign div_one  = num_q >= den_q;
	assign den_u    = den_q;
	assign rsh      = {rem_q[DIV_W-2:0], 1'b0};
	assign rge      = rsh >= den_u;
	assign qnext    = {quo_q[WFRAC-2:0], rge};
	assign div_fin  = (dstep_q == 5'd0) ? (div_zero || div_one) : (dstep_q == 5'(WFRAC));
	assign vc_x     = DIV_W'(vc_q);
	always_comb begin
		if (dstep_q != 5'd0)
			fin_w = {1'b0, qnext};
		else if (div_zero)
			fin_w = '0;
		else
			fin_w = {1'b1, {WFRAC{1'b0}}};
	end

	// blend: base + round(e1*w1 + e2*w2)
	logic signed [DIFF_W-1:0] esel;
	logic signed [WFRAC+1:0]  wsel;
	logic signed [50:0]       bprod;
	logic signed [51:0]       t_a, t_b, t_sum;
	logic signed [27:0]       qv;
	logic signed [28:0]       base_x, qv_x, s_sum;
	coord_t                   base_sel, s_sat;

	always_comb begin
		if (term_q) begin
			esel = ac_q[coord_q];
			wsel = {1'b0, w2_q};
		end else begin
			case (region_q)
				R_AC:    esel = ac_q[coord_q];
				R_BC:    esel = bc_q[coord_q];
				default: esel = ab_q[coord_q];
			endcase
			wsel = {1'b0, w1_q};
		end
	end
	assign bprod    = esel * wsel;
	assign t_a      = 52'(bacc_q);
	assign t_b      = 52'(bprod);
	assign t_sum    = t_a + t_b + 52'sd8388608;
	assign qv       = t_sum[51:WFRAC];
	assign base_sel = (region_q == R_BC) ? b_q[coord_q] : a_q[coord_q];
	assign base_x   = 29'(base_sel);
	assign qv_x     = 29'(qv);
	assign s_sum    = base_x + qv_x;
	always_comb begin
		if (s_sum > 29'sd8388607)        s_sat = 24'sh7FFFFF;
		else if (s_sum < -29'sd8388608)  s_sat = 24'sh800000;
		else                             s_sat = s_sum[COORD_W-1:0];
	end

	// squared distance
	logic signed [DIFF_W-1:0]   qe, pe, dq;
	logic signed [2*DIFF_W-1:0] sqp;
	logic [SQ_W-1:0]            sq_next;

	assign qe      = DIFF_W'(q_q[coord_q]);
	assign pe      = DIFF_W'(p[coord_q]);
	assign dq      = qe - pe;
	assign sqp     = dq * dq;
	assign sq_next = ((coord_q == 2'd0) ? '0 : sq_q) + sqp[SQ_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (in_valid) state_d = F_DIFF;
			F_DIFF:  state_d = F_DOT;
			F_DOT:   if (comp_q == 2'd2 && dot_idx_q == 3'd5) state_d = F_WMUL;
			F_WMUL:  if (wdig_q == 2'(NDIG - 1) && widx_q == 3'd5) state_d = F_VSUM;
			F_VSUM:  state_d = F_CLASS;
			F_CLASS: state_d = is_vertex ? F_SQ : F_DIV;
			F_DIV:   if (div_fin && (div_sel_q || region_q != R_FACE)) state_d = F_BLEND;
			F_BLEND: if (term_q && coord_q == 2'd2) state_d = F_SQ;
			F_SQ:    if (coord_q == 2'd2) state_d = F_PUSH;
			F_PUSH:  if (cand_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		cand_valid = 1'b0;
		unique case (state_q)
			F_IDLE:  in_ready = 1'b1;
			F_PUSH:  cand_valid = 1'b1;
			default: ;
		endcase
	end

	assign cand.px   = q_q[0];
	assign cand.py   = q_q[1];
	assign cand.pz   = q_q[2];
	assign cand.sq   = sq_q;
	assign cand.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			comp_q    <= '0;
			dot_idx_q <= '0;
			widx_q    <= '0;
			wdig_q    <= '0;
			dstep_q   <= '0;
			div_sel_q <= 1'b0;
			coord_q   <= '0;
			term_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						a_q[0] <= vert_a.x; a_q[1] <= vert_a.y; a_q[2] <= vert_a.z;
						b_q[0] <= vert_b.x; b_q[1] <= vert_b.y; b_q[2] <= vert_b.z;
						c_q[0] <= vert_c.x; c_q[1] <= vert_c.y; c_q[2] <= vert_c.z;
						last_q    <= last_in;
						comp_q    <= '0;
						dot_idx_q <= '0;
						widx_q    <= '0;
						wdig_q    <= '0;
					end
				end
				F_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						ab_q[i] <= DIFF_W'(b_q[i]) - DIFF_W'(a_q[i]);
						ac_q[i] <= DIFF_W'(c_q[i]) - DIFF_W'(a_q[i]);
						bc_q[i] <= DIFF_W'(c_q[i]) - DIFF_W'(b_q[i]);
						ap_q[i] <= DIFF_W'(p[i]) - DIFF_W'(a_q[i]);
						bp_q[i] <= DIFF_W'(p[i]) - DIFF_W'(b_q[i]);
						cp_q[i] <= DIFF_W'(p[i]) - DIFF_W'(c_q[i]);
					end
				end
				F_DOT: begin
					acc_q <= dsum;
					if (comp_q == 2'd2) begin
						dot_q[dot_idx_q] <= dsum;
						comp_q           <= '0;
						dot_idx_q        <= dot_idx_q + 3'd1;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				F_WMUL: begin
					wacc_q <= wsum;
					if (wdig_q == 2'(NDIG - 1)) begin
						prod_q[widx_q] <= wprod;
						wdig_q         <= '0;
						widx_q         <= widx_q + 3'd1;
					end else begin
						wdig_q <= wdig_q + 2'd1;
					end
				end
				F_VSUM: begin
					vc_q <= p0x - p1x;
					vb_q <= p2x - p3x;
					va_q <= p4x - p5x;
				end
				F_CLASS: begin
					region_q  <= region_c;
					num_q     <= num_c;
					den_q     <= den_c;
					dstep_q   <= '0;
					div_sel_q <= 1'b0;
					coord_q   <= '0;
					term_q    <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						case (region_c)
							R_A:     q_q[i] <= a_q[i];
							R_B:     q_q[i] <= b_q[i];
							R_C:     q_q[i] <= c_q[i];
							default: ;
						endcase
					end
				end
				F_DIV: begin
					if (div_fin) begin
						dstep_q <= '0;
						if (div_sel_q) begin
							w2_q <= fin_w;
						end else begin
							w1_q <= fin_w;
							w2_q <= '0;
							if (region_q == R_FACE) begin
								div_sel_q <= 1'b1;
								num_q     <= vc_x;
							end
						end
					end else if (dstep_q == 5'd0) begin
						rem_q   <= num_q;
						quo_q   <= '0;
						dstep_q <= 5'd1;
					end else begin
						rem_q   <= rge ? (rsh - den_u) : rsh;
						quo_q   <= qnext;
						dstep_q <= dstep_q + 5'd1;
					end
				end
				F_BLEND: begin
					if (!term_q) begin
						bacc_q <= bprod;
						term_q <= 1'b1;
					end else begin
						q_q[coord_q] <= s_sat;
						term_q       <= 1'b0;
						coord_q      <= (coord_q == 2'd2) ? 2'd0 : coord_q + 2'd1;
					end
				end
				F_SQ: begin
					sq_q    <= sq_next;
					coord_q <= (coord_q == 2'd2) ? 2'd0 : coord_q + 2'd1;
				end
				F_PUSH:  ;
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/npts_queue.sv
module npts_queue import npts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  cand_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output cand_t rd_data
);

	cand_t      slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/npts_back.sv
module npts_back import npts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cand_valid,
	output logic               cand_ready,
	input  cand_t              cand,
	output logic               out_valid,
	input  logic               out_ready,
	output coord_t             out_x,
	output coord_t             out_y,
	output coord_t             out_z,
	output logic [SQ_W-1:0]    out_sq,
	output logic [DIST_W-1:0]  out_dist,
	output logic [FACE_W-1:0]  out_face
);

	back_state_t state_q, state_d;

	logic [SQ_W-1:0]   best_sq_q;
	coord_t            best_x_q, best_y_q, best_z_q;
	logic [FACE_W-1:0] best_face_q, face_cnt_q;

	logic [SQ_W-1:0]   rv_q, root_q, bit_q;
	logic [4:0]        step_q;

	logic              take, better;
	logic [SQ_W-1:0]   fin_sq;
	coord_t            fin_x, fin_y, fin_z;
	logic [FACE_W-1:0] fin_face;
	logic [SQ_W:0]     trial;
	logic              tge;
	logic [SQ_W-1:0]   root_next;

	assign take     = cand_valid && cand_ready;
	assign better   = cand.sq < best_sq_q;
	assign fin_sq   = better ? cand.sq : best_sq_q;
	assign fin_x    = better ? cand.px : best_x_q;
	assign fin_y    = better ? cand.py : best_y_q;
	assign fin_z    = better ? cand.pz : best_z_q;
	assign fin_face = better ? face_cnt_q : best_face_q;

	assign trial     = {1'b0, root_q} + {1'b0, bit_q};
	assign tge       = {1'b0, rv_q} >= trial;
	assign root_next = tge ? ((root_q >> 1) + bit_q) : (root_q >> 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (take && cand.last) state_d = B_SQRT;
			B_SQRT:  if (step_q == 5'(DIST_W - 1)) state_d = B_OUT;
			B_OUT:   if (out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cand_ready = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			B_IDLE:  cand_ready = 1'b1;
			B_OUT:   out_valid  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			best_sq_q   <= '1;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_z_q    <= '0;
			best_face_q <= '0;
			face_cnt_q  <= '0;
			step_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_IDLE && take) begin
				if (cand.last) begin
					out_x       <= fin_x;
					out_y       <= fin_y;
					out_z       <= fin_z;
					out_sq      <= fin_sq;
					out_face    <= fin_face;
					rv_q        <= fin_sq;
					root_q      <= '0;
					bit_q       <= SQ_W'(1) << (SQ_W - 2);
					step_q      <= '0;
					best_sq_q   <= '1;
					best_x_q    <= '0;
					best_y_q    <= '0;
					best_z_q    <= '0;
					best_face_q <= '0;
					face_cnt_q  <= '0;
				end else begin
					best_sq_q   <= fin_sq;
					best_x_q    <= fin_x;
					best_y_q    <= fin_y;
					best_z_q    <= fin_z;
					best_face_q <= fin_face;
					if (face_cnt_q < FACE_W'(FACE_LIMIT))
						face_cnt_q <= face_cnt_q + 1'b1;
				end
			end
			if (state_q == B_SQRT) begin
				if (tge) rv_q <= rv_q - trial[SQ_W-1:0];
				root_q <= root_next;
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 5'd1;
				if (step_q == 5'(DIST_W - 1))
					out_dist <= root_next[DIST_W-1:0];
			end
		end
	end

endmodule

>>> hw/rtl/npts_checker.sv
module npts_checker import npts_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [SQ_W-1:0]    squared_distance,
	input logic [DIST_W-1:0]  distance
);

	logic [SQ_W:0] root_sq, next_sq, sq_x;

	assign root_sq = {26'b0, distance} * {26'b0, distance};
	assign next_sq = ({26'b0, distance} + 51'd1) * ({26'b0, distance} + 51'd1);
	assign sq_x    = {1'b0, squared_distance};

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (root_sq <= sq_x) && (next_sq > sq_x))
		else $error("distance is not the floor root of squared_distance");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(squared_distance))
		else $error("result dropped or changed while stalled");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule

bind nearest_point_on_triangle_set_unit npts_checker u_npts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.squared_distance (squared_distance),
	.distance         (distance)
);
